/* src/hbpam_pkg.sv */
`timescale 1ns / 1ps

package hbpam_pkg;

    localparam int SPACE_BYTES = 256;
    localparam int ADDR_W      = $clog2(SPACE_BYTES);

    localparam int BASE_W = 20;
    localparam int SIZE_W = 17;

    // Identity registers: IDs, revision/class block, header type
    localparam logic [7:0] ID_FIRST_OFF    = 8'h00;
    localparam logic [7:0] ID_LAST_OFF     = 8'h03;
    localparam logic [7:0] CLASS_FIRST_OFF = 8'h08;
    localparam logic [7:0] CLASS_LAST_OFF  = 8'h0B;
    localparam logic [7:0] HDR_TYPE_OFF    = 8'h0E;

    localparam logic [7:0] PAM0_OFF      = 8'h59;
    localparam logic [7:0] PAM_FIRST_OFF = 8'h5A;
    localparam logic [7:0] PAM_LAST_OFF  = 8'h5F;
    localparam logic [7:0] NOSTORE_OFF   = 8'hA9;
    localparam logic [7:0] ABSENT_BYTE   = 8'hFF;
    localparam logic [7:0] LO_NIBBLE     = 8'h0F;
    localparam logic [7:0] HI_NIBBLE     = 8'hF0;
    localparam logic [7:0] SHADOW_BIT    = 8'h10;

    localparam logic [BASE_W-1:0] PAM0_BASE = 20'hF0000;
    localparam logic [BASE_W-1:0] PAM_BASE  = 20'hC0000;
    localparam logic [BASE_W-1:0] PAM_STEP  = 20'h04000;
    localparam logic [SIZE_W-1:0] SIZE_64K  = 17'h10000;
    localparam logic [SIZE_W-1:0] SIZE_16K  = 17'h04000;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // One result transfer
    typedef struct packed {
        logic [7:0]        read_data;
        logic              map_valid;
        logic [BASE_W-1:0] region_base;
        logic [SIZE_W-1:0] region_size;
        logic              read_internal;
        logic              write_internal;
        logic              shadow_bios;
        logic              last;
    } t_result;

    typedef struct packed {
        logic capture;      // latch the incoming access, launch the store read
        logic evaluate;     // old byte is on the read port: decode, update store
        logic show_second;  // present the second region event
    } t_dp_cmd;

    typedef struct packed {
        logic two_results;
    } t_dp_stat;

    // Writes to the identity registers are dropped
    function automatic logic f_is_ident(input logic [ADDR_W-1:0] off);
        return (off <= ID_LAST_OFF) ||
               ((off >= CLASS_FIRST_OFF) && (off <= CLASS_LAST_OFF)) ||
               (off == HDR_TYPE_OFF);
    endfunction

    // Power-on contents of the configuration space
    function automatic logic [7:0] f_init_byte(input logic [ADDR_W-1:0] off);
        logic [7:0] b;
        case (off)
            8'h00:   b = 8'h86;
            8'h01:   b = 8'h80;
            8'h02:   b = 8'h92;
            8'h03:   b = 8'h71;
            8'h04:   b = 8'h06;
            8'h07:   b = 8'h02;
            8'h08:   b = 8'h01;
            8'h0B:   b = 8'h06;
            8'h52:   b = 8'h42;
            8'h57:   b = 8'h01;
            8'h60:   b = 8'h01;
            8'h67:   b = 8'h80;
            8'h71:   b = 8'h1F;
            8'h72:   b = 8'h02;
            8'h74:   b = 8'h0E;
            8'h78:   b = 8'h23;
            8'h7B:   b = 8'h38;
            8'h90:   b = 8'h80;
            8'h94:   b = 8'h04;
            8'h95:   b = 8'h61;
            8'h99:   b = 8'h05;
            8'hA4:   b = 8'h03;
            8'hA5:   b = 8'h02;
            8'hA7:   b = 8'h1F;
            8'hC8:   b = 8'h18;
            8'hC9:   b = 8'h0C;
            8'hF3:   b = 8'hF8;
            8'hF8:   b = 8'h20;
            8'hF9:   b = 8'h0F;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* src/hbpam_ram.sv */
`timescale 1ns / 1ps

module hbpam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

/* src/hbpam_datapath.sv */
`timescale 1ns / 1ps

module hbpam_datapath
    import hbpam_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic              i_mode,
    input  logic [2:0]        i_function_number,
    input  logic [ADDR_W-1:0] i_offset,
    input  logic [7:0]        i_write_data,
    output t_dp_stat          o_stat,
    output t_result           o_result
);

    logic              r_mode;
    logic [2:0]        r_func;
    logic [ADDR_W-1:0] r_off;
    logic [7:0]        r_val;
    logic [SPACE_BYTES-1:0] r_vld;
    logic              r_shadow;
    logic              r_two;
    t_result           r_res0;
    t_result           r_res1;

    logic [7:0]        ram_q;
    logic [7:0]        old_byte;
    logic [7:0]        diff;
    logic              is_ident;
    logic              do_write;
    logic              is_pam0;
    logic              is_pamn;
    logic [2:0]        pam_idx;
    logic [BASE_W-1:0] base_lo;
    logic              ev_lo;
    logic              ev_hi;
    logic              store_en;
    logic              n_shadow;
    t_result           ev_lo_res;
    t_result           ev_hi_res;
    t_result           empty_res;
    t_result           n_res0;

    hbpam_ram #(
        .WIDTH (8),
        .DEPTH (SPACE_BYTES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (store_en),
        .i_wr_addr (r_off),
        .i_wr_data (r_val),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (i_offset),
        .o_rd_data (ram_q)
    );

    always_comb begin
        old_byte = r_vld[r_off] ? ram_q : f_init_byte(r_off);
        diff     = old_byte ^ r_val;

        is_ident = f_is_ident(r_off);

        do_write = (r_mode == MODE_WRITE) && (r_func == 3'd0) && !is_ident;
        is_pam0  = (r_off == PAM0_OFF);
        is_pamn  = (r_off >= PAM_FIRST_OFF) && (r_off <= PAM_LAST_OFF);
        pam_idx  = r_off[2:0] - PAM_FIRST_OFF[2:0];
        base_lo  = PAM_BASE + {2'b00, pam_idx, 15'd0};

        ev_lo = do_write && is_pamn && ((diff & LO_NIBBLE) != 8'h00);
        ev_hi = do_write && (is_pam0 || is_pamn) && ((diff & HI_NIBBLE) != 8'h00);

        store_en = i_cmd.evaluate && do_write && (r_off != NOSTORE_OFF);

        // Shadow flag follows bit 4 when the PAM0 high nibble changes
        n_shadow = r_shadow;
        if (ev_hi && is_pam0) begin
            n_shadow = ((r_val & SHADOW_BIT) != 8'h00);
        end

        empty_res             = '0;
        empty_res.shadow_bios = n_shadow;
        empty_res.last        = 1'b1;

        ev_lo_res                = empty_res;
        ev_lo_res.map_valid      = 1'b1;
        ev_lo_res.region_base    = base_lo;
        ev_lo_res.region_size    = SIZE_16K;
        ev_lo_res.read_internal  = r_val[0];
        ev_lo_res.write_internal = r_val[1];
        ev_lo_res.last           = !ev_hi;

        ev_hi_res                = empty_res;
        ev_hi_res.map_valid      = 1'b1;
        ev_hi_res.region_base    = is_pam0 ? PAM0_BASE : (base_lo + PAM_STEP);
        ev_hi_res.region_size    = is_pam0 ? SIZE_64K : SIZE_16K;
        ev_hi_res.read_internal  = r_val[4];
        ev_hi_res.write_internal = r_val[5];

        if (r_mode == MODE_READ) begin
            n_res0           = empty_res;
            n_res0.read_data = (r_func != 3'd0) ? ABSENT_BYTE : old_byte;
        end else if (ev_lo) begin
            n_res0 = ev_lo_res;
        end else if (ev_hi) begin
            n_res0 = ev_hi_res;
        end else begin
            n_res0 = empty_res;
        end
    end

    // Capture the access, then fold the decode into the result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_func <= i_function_number;
            r_off  <= i_offset;
            r_val  <= i_write_data;
        end
        if (i_cmd.evaluate) begin
            r_res0 <= n_res0;
            r_res1 <= ev_hi_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_shadow <= 1'b0;
            r_two    <= 1'b0;
        end else if (i_cmd.evaluate) begin
            if (store_en) begin
                r_vld[r_off] <= 1'b1;
            end
            r_shadow <= n_shadow;
            r_two    <= ev_lo && ev_hi;
        end
    end

    assign o_stat.two_results = r_two;
    assign o_result           = i_cmd.show_second ? r_res1 : r_res0;

endmodule

/* src/hbpam_ctrl.sv */
`timescale 1ns / 1ps

module hbpam_ctrl
    import hbpam_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOOK  = 4'b0010,
        ST_SEND0 = 4'b0100,
        ST_SEND1 = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_SEND0;
            end
            ST_SEND0: begin
                if (i_out_ready) begin
                    n_state = i_stat.two_results ? ST_SEND1 : ST_IDLE;
                end
            end
            ST_SEND1: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready        = (r_state == ST_IDLE);
    assign o_out_valid       = (r_state == ST_SEND0) || (r_state == ST_SEND1);
    assign o_cmd.capture     = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.evaluate    = (r_state == ST_LOOK);
    assign o_cmd.show_second = (r_state == ST_SEND1);

endmodule

/* src/host_bridge_config_space_pam_core.sv */
`timescale 1ns / 1ps

// Configuration space of a host bridge (function 0 only) with PAM shadow control.
// Slave channel: one byte access per transfer (read or write, function, offset, data).
// Master channel: one or two result transfers per access; tlast marks the final one.
// A read returns the stored byte (0xFF for an absent function). A write to a PAM
// register yields one region routing event per changed nibble (high nibble only for
// PAM0), low nibble first; any other access yields a single result with map_valid low.
// Sequence: the byte store is read (registered) as the access is accepted, then
// decoded into the result register, from which the first result is presented.
// An access occupies the block until all its results are delivered, receiver
// stalls included; the store's read port and the single result register set
// this, and a new access is taken only once all results of the previous one
// are delivered.
// Stall: a result is held steady on m_axis_tdata/tlast until m_axis_tready.
// Reset: the byte store reads back its power-on table at once (per-byte valid
// bits fall back to it, no clearing pass) and the shadow BIOS flag clears.

module host_bridge_config_space_pam_core
    import hbpam_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] mode, [3:1] function_number, [11:4] offset, [19:12] write_data
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data, [8] map_valid, [28:9] region_base, [45:29] region_size,
    // [46] read_internal, [47] write_internal, [48] shadow_bios
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_result  res;

    // Sequence each access: capture, decode, then hand out results
    hbpam_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Byte store, PAM compare and result registers
    hbpam_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_mode            (s_axis_tdata[0]),
        .i_function_number (s_axis_tdata[3:1]),
        .i_offset          (s_axis_tdata[11:4]),
        .i_write_data      (s_axis_tdata[19:12]),
        .o_stat            (stat),
        .o_result          (res)
    );

    // Pack the held result, zero-fill to whole bytes
    assign m_axis_tdata = {7'd0, res.shadow_bios, res.write_internal, res.read_internal,
                           res.region_size, res.region_base, res.map_valid,
                           res.read_data};
    assign m_axis_tlast = res.last;

endmodule
